>>> src/nnst_pkg.sv
// ----------------------------------------------------------------------------
// nnst_pkg
// Types, constants and shared arithmetic for the spot tracker.
// ----------------------------------------------------------------------------
package nnst_pkg;

	localparam int MAX_TRACKS_DEF = 16;

	localparam int D2W  = 33;   // squared distance, 1/16 pixel units
	localparam int JW   = 14;   // jump radius in 1/16 pixel
	localparam int J2W  = 28;   // squared jump radius
	localparam int NUMW = 22;   // scaled distance before the divide

	localparam logic [16:0] AGE_CAP   = 17'd100000;
	localparam logic [8:0]  POS_BASE  = 9'd72;
	localparam logic [7:0]  POS_SPAN  = 8'd146;
	localparam logic [8:0]  RAD_ALPHA = 9'd64;

	// configuration register indexes
	localparam logic [1:0] CFG_MAX_JUMP = 2'd0;
	localparam logic [1:0] CFG_CONFIRM  = 2'd1;
	localparam logic [1:0] CFG_DROP     = 2'd2;

	// commands broadcast to the cell row
	localparam logic [2:0] OP_NONE  = 3'd0;
	localparam logic [2:0] OP_MATCH = 3'd1;
	localparam logic [2:0] OP_NEW   = 3'd2;
	localparam logic [2:0] OP_MISS  = 3'd3;
	localparam logic [2:0] OP_PACK  = 3'd4;

	typedef struct packed {
		logic        kind;
		logic [15:0] spot_x;
		logic [15:0] spot_y;
		logic [15:0] spot_radius;
		logic        has_radius;
	} in_item_t;

	typedef struct packed {
		logic [15:0] track_number;
		logic [16:0] track_age;
		logic        onset;
		logic        confirmed;
		logic [15:0] smooth_x;
		logic [15:0] smooth_y;
		logic [15:0] smooth_radius;
		logic        table_full;
	} out_item_t;

	typedef struct packed {
		logic        valid;
		logic        claimed;
		logic [15:0] cx;
		logic [15:0] cy;
		logic [15:0] smx;
		logic [15:0] smy;
		logic [15:0] smr;
		logic [16:0] age;
		logic [7:0]  misses;
		logic [15:0] ident;
	} slot_t;

	typedef struct packed {
		logic           found;
		logic [D2W-1:0] d2;
		logic [15:0]    smx;
		logic [15:0]    smy;
		logic [15:0]    smr;
		logic [16:0]    age;
		logic [15:0]    ident;
	} cand_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [15:0] cx;
		logic [15:0] cy;
		logic [15:0] smx;
		logic [15:0] smy;
		logic [15:0] smr;
		logic [16:0] age;
		logic [15:0] ident;
		logic [7:0]  drop;
	} cmd_t;

	// (s*(256-a) + v*a + 128) >> 8
	function automatic logic [15:0] blend_q8(input logic [15:0] s, input logic [15:0] v,
		input logic [8:0] a);
		logic [25:0] acc;
		acc = ({10'd0, s} * {17'd0, 9'd256 - a}) + ({10'd0, v} * {17'd0, a}) + 26'd128;
		return acc[23:8];
	endfunction

endpackage

>>> src/nnst_alpha.sv
// ----------------------------------------------------------------------------
// nnst_alpha
// Position weight from a squared distance: bit-serial square root, then a
// restoring divide of the clamped distance by the jump radius.
// ----------------------------------------------------------------------------
module nnst_alpha (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [nnst_pkg::J2W-1:0] d2,
	input  logic [nnst_pkg::JW-1:0]  jq,
	output logic                  done,
	output logic [8:0]            alpha
);
	import nnst_pkg::*;

	localparam logic [1:0] A_IDLE  = 2'd0;
	localparam logic [1:0] A_SQRT  = 2'd1;
	localparam logic [1:0] A_SCALE = 2'd2;
	localparam logic [1:0] A_DIV   = 2'd3;

	logic [1:0]      state_q;
	logic [3:0]      bit_q;
	logic [J2W-1:0]  d2_q;
	logic [JW-1:0]   jq_q;
	logic [JW-1:0]   root_q;
	logic [NUMW-1:0] num_q;
	logic [7:0]      quo_q;
	logic            done_q;
	logic [8:0]      alpha_q;

	logic [JW-1:0]   trial;
	logic [J2W-1:0]  trial_sq;
	logic [JW-1:0]   dclamp;
	logic [NUMW-1:0] dsub;

	assign trial    = root_q | (JW'(1) << bit_q);
	assign trial_sq = {14'd0, trial} * {14'd0, trial};
	assign dclamp   = (root_q > jq_q) ? jq_q : root_q;
	assign dsub     = {8'd0, jq_q} << bit_q[2:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == A_DIV) && (bit_q == 4'd0);
			unique case (state_q)
				A_IDLE: begin
					if (start) begin
						d2_q    <= d2;
						jq_q    <= jq;
						root_q  <= '0;
						bit_q   <= 4'(JW - 1);
						state_q <= A_SQRT;
					end
				end
				A_SQRT: begin
					if (trial_sq <= d2_q)
						root_q <= trial;
					if (bit_q == 4'd0)
						state_q <= A_SCALE;
					else
						bit_q <= bit_q - 4'd1;
				end
				A_SCALE: begin
					num_q   <= NUMW'({14'd0, POS_SPAN} * {8'd0, dclamp});
					quo_q   <= '0;
					bit_q   <= 4'd7;
					state_q <= A_DIV;
				end
				A_DIV: begin
					if (num_q >= dsub) begin
						num_q <= num_q - dsub;
						quo_q[bit_q[2:0]] <= 1'b1;
					end
					if (bit_q == 4'd0) begin
						alpha_q <= POS_BASE + {1'b0, quo_q}
							+ {8'd0, (num_q >= dsub)};
						state_q <= A_IDLE;
					end else
						bit_q <= bit_q - 4'd1;
				end
				default: state_q <= A_IDLE;
			endcase
		end
	end

	assign done  = done_q;
	assign alpha = alpha_q;

endmodule

>>> src/nnst_cell.sv
// ----------------------------------------------------------------------------
// nnst_cell
// One track slot: its own distance pipeline, a stage of the best-match
// chain, and the shift stage used to close gaps at frame end.
// ----------------------------------------------------------------------------
module nnst_cell #(
	parameter int MAX_TRACKS = nnst_pkg::MAX_TRACKS_DEF,
	parameter int CELL_ID    = 0,
	localparam int IW        = $clog2(MAX_TRACKS)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  nnst_pkg::cmd_t         cmd,
	input  logic [IW-1:0]          wr_idx,
	input  logic [nnst_pkg::J2W-1:0] jump2,
	input  logic                   hole_in,
	output logic                   hole_out,
	input  nnst_pkg::slot_t        upper,
	output nnst_pkg::slot_t        slot,
	input  nnst_pkg::cand_t        cand_in,
	input  logic [IW-1:0]          cand_idx_in,
	output nnst_pkg::cand_t        cand_out,
	output logic [IW-1:0]          cand_idx_out
);
	import nnst_pkg::*;

	logic        valid_q;
	logic        claimed_q;
	logic [15:0] cx_q, cy_q, smx_q, smy_q, smr_q, ident_q;
	logic [16:0] age_q;
	logic [7:0]  misses_q;

	logic [15:0]    dx_s1, dy_s1;
	logic [31:0]    dxx_s2, dyy_s2;
	logic [D2W-1:0] d2_s3;
	cand_t          cand_q;
	logic [IW-1:0]  cand_idx_q;

	logic   elig, take, shift, miss;
	logic [8:0] m_inc;

	assign hole_out = hole_in | ~valid_q;
	assign shift    = hole_out;
	assign elig     = valid_q & ~claimed_q & (d2_s3 <= {5'd0, jump2});
	assign take     = elig & (~cand_in.found | (d2_s3 <= cand_in.d2));
	assign miss     = valid_q & ~claimed_q;
	assign m_inc    = {1'b0, misses_q} + 9'd1;

	// distance pipeline: absolute differences, then squares, then their sum, each registered
	always_ff @(posedge clk) begin
		dx_s1  <= (cx_q >= cmd.cx) ? cx_q - cmd.cx : cmd.cx - cx_q;
		dy_s1  <= (cy_q >= cmd.cy) ? cy_q - cmd.cy : cmd.cy - cy_q;
		dxx_s2 <= dx_s1 * dx_s1;
		dyy_s2 <= dy_s1 * dy_s1;
		d2_s3  <= {1'b0, dxx_s2} + {1'b0, dyy_s2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q     <= '0;
			cand_idx_q <= '0;
		end else if (take) begin
			cand_q     <= '{found: 1'b1, d2: d2_s3, smx: smx_q, smy: smy_q,
				smr: smr_q, age: age_q, ident: ident_q};
			cand_idx_q <= IW'(CELL_ID);
		end else begin
			cand_q     <= cand_in;
			cand_idx_q <= cand_idx_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			claimed_q <= 1'b0;
		end else begin
			unique case (cmd.op)
				OP_MATCH: if (wr_idx == IW'(CELL_ID)) claimed_q <= 1'b1;
				OP_NEW: begin
					if (~valid_q & ~hole_in) begin
						valid_q   <= 1'b1;
						claimed_q <= 1'b1;
					end
				end
				OP_MISS: begin
					claimed_q <= 1'b0;
					if (miss && m_inc > {1'b0, cmd.drop})
						valid_q <= 1'b0;
				end
				OP_PACK: begin
					if (shift) begin
						valid_q   <= upper.valid;
						claimed_q <= upper.claimed;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_MATCH, OP_NEW: begin
				if ((cmd.op == OP_MATCH && wr_idx == IW'(CELL_ID))
					|| (cmd.op == OP_NEW && ~valid_q && ~hole_in)) begin
					cx_q     <= cmd.cx;
					cy_q     <= cmd.cy;
					smx_q    <= cmd.smx;
					smy_q    <= cmd.smy;
					smr_q    <= cmd.smr;
					age_q    <= cmd.age;
					misses_q <= '0;
					if (cmd.op == OP_NEW)
						ident_q <= cmd.ident;
				end
			end
			OP_MISS: begin
				if (miss) begin
					misses_q <= m_inc[7:0];
					age_q    <= '0;
				end
			end
			OP_PACK: begin
				if (shift) begin
					cx_q     <= upper.cx;
					cy_q     <= upper.cy;
					smx_q    <= upper.smx;
					smy_q    <= upper.smy;
					smr_q    <= upper.smr;
					age_q    <= upper.age;
					misses_q <= upper.misses;
					ident_q  <= upper.ident;
				end
			end
			default: ;
		endcase
	end

	assign slot = '{valid: valid_q, claimed: claimed_q, cx: cx_q, cy: cy_q, smx: smx_q,
		smy: smy_q, smr: smr_q, age: age_q, misses: misses_q, ident: ident_q};
	assign cand_out     = cand_q;
	assign cand_idx_out = cand_idx_q;

endmodule

>>> src/nearest_neighbour_spot_tracker.sv
// ----------------------------------------------------------------------------
// nearest_neighbour_spot_tracker
// Greedy nearest-neighbour spot tracker with smoothed position and radius.
// ----------------------------------------------------------------------------
// Spots enter one transaction at a time on the spot channel; a transaction
// with kind set closes the frame and gives no result. Each spot gives exactly
// one result transaction. Tracks live in a row of MAX_TRACKS cells kept in
// creation order. A spot is taken, then the distance pipes settle and the
// best-match wave passes along the row; when a track matched, the square
// root and divide unit and a blend step follow before the write-back. An end
// of frame runs a miss step, then a shift pass that closes gaps left by freed
// tracks. A finished result waits in the output register; the next transaction
// is taken meanwhile, and the block only holds at its write-back step while the
// previous result is still unread. Configuration writes are always taken.
module nearest_neighbour_spot_tracker #(
	parameter int MAX_TRACKS = nnst_pkg::MAX_TRACKS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                spot_valid,
	output logic                spot_ready,
	input  nnst_pkg::in_item_t  spot,
	output logic                result_valid,
	input  logic                result_ready,
	output nnst_pkg::out_item_t result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [9:0]          cfg_data
);
	import nnst_pkg::*;

	localparam int IW = $clog2(MAX_TRACKS);
	localparam int CW = $clog2(MAX_TRACKS + 4) + 1;

	// sequencer codes
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_ALPHA  = 3'd2;
	localparam logic [2:0] ST_BLEND  = 3'd3;
	localparam logic [2:0] ST_RESULT = 3'd4;
	localparam logic [2:0] ST_MISS   = 3'd5;
	localparam logic [2:0] ST_PACK   = 3'd6;

	// configuration registers
	logic [9:0]     max_jump_q;
	logic [7:0]     confirm_q;
	logic [7:0]     drop_q;
	logic [J2W-1:0] jump2_q;
	logic [JW-1:0]  jump16, jq;
	logic [7:0]     ck;

	// sequencer and spot registers
	logic [2:0]    state_q;
	logic [CW-1:0] cnt_q;
	logic [15:0]   sx_q, sy_q, sr_q;
	logic [15:0]   next_ident_q;
	cand_t         best_q;
	logic [IW-1:0] best_idx_q;
	logic [15:0]   bx_q, by_q, br_q;
	logic          alpha_start_q;
	logic          alpha_done;
	logic [8:0]    alpha;
	logic [8:0]    alpha_q;
	out_item_t     result_q;
	out_item_t     result_d;
	logic          result_valid_q;

	// cell row
	slot_t         slots     [MAX_TRACKS];
	slot_t         uppers    [MAX_TRACKS];
	cand_t         cands     [MAX_TRACKS + 1];
	logic [IW-1:0] cand_idxs [MAX_TRACKS + 1];
	logic [MAX_TRACKS:0]   holes;
	logic [MAX_TRACKS-1:0] valid_vec, claimed_vec;
	cmd_t          cmd;

	logic          fire, full, scan_end;
	logic [16:0]   age_new;

	assign cfg_ready = 1'b1;
	assign jump16    = {max_jump_q, 4'd0};
	assign jq        = (max_jump_q == '0) ? JW'(16) : jump16;
	assign ck        = (confirm_q == '0) ? 8'd1 : confirm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_jump_q <= 10'd64;
			confirm_q  <= 8'd3;
			drop_q     <= 8'd5;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MAX_JUMP: max_jump_q <= cfg_data;
				CFG_CONFIRM:  confirm_q  <= cfg_data[7:0];
				CFG_DROP:     drop_q     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// squared jump radius, registered from the jump register
	always_ff @(posedge clk) begin
		jump2_q <= {14'd0, jump16} * {14'd0, jump16};
	end

	// row of track cells; the best-match candidate ripples upward one cell a cycle
	assign holes[0]     = 1'b0;
	assign cands[0]     = '0;
	assign cand_idxs[0] = '0;

	for (genvar k = 0; k < MAX_TRACKS; k++) begin : g_cell
		if (k == MAX_TRACKS - 1) begin : g_top
			assign uppers[k] = '0;
		end else begin : g_mid
			assign uppers[k] = slots[k + 1];
		end

		nnst_cell #(
			.MAX_TRACKS(MAX_TRACKS),
			.CELL_ID   (k)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.wr_idx      (best_idx_q),
			.jump2       (jump2_q),
			.hole_in     (holes[k]),
			.hole_out    (holes[k + 1]),
			.upper       (uppers[k]),
			.slot        (slots[k]),
			.cand_in     (cands[k]),
			.cand_idx_in (cand_idxs[k]),
			.cand_out    (cands[k + 1]),
			.cand_idx_out(cand_idxs[k + 1])
		);

		assign valid_vec[k]   = slots[k].valid;
		assign claimed_vec[k] = slots[k].claimed;
	end

	// the row stays compacted, so the table is full exactly when the last cell is live
	assign full = slots[MAX_TRACKS - 1].valid;

	nnst_alpha u_alpha (
		.clk   (clk),
		.arst_n(arst_n),
		.start (alpha_start_q),
		.d2    (best_q.d2[J2W-1:0]),
		.jq    (jq),
		.done  (alpha_done),
		.alpha (alpha)
	);

	assign age_new  = (best_q.age < AGE_CAP) ? best_q.age + 17'd1 : AGE_CAP;
	assign fire     = (state_q == ST_RESULT) & (~result_valid_q | result_ready);
	// scan ends once the distance pipes have settled and the wave has crossed every cell
	assign scan_end = (state_q == ST_SCAN) && (cnt_q == CW'(MAX_TRACKS + 3));

	// command to the row
	always_comb begin
		cmd       = '0;
		cmd.cx    = sx_q;
		cmd.cy    = sy_q;
		cmd.drop  = drop_q;
		cmd.ident = next_ident_q;
		if (best_q.found) begin
			cmd.smx = bx_q;
			cmd.smy = by_q;
			cmd.smr = br_q;
			cmd.age = age_new;
		end else begin
			cmd.smx = sx_q;
			cmd.smy = sy_q;
			cmd.smr = sr_q;
			cmd.age = 17'd1;
		end
		unique case (state_q)
			ST_RESULT: begin
				if (fire && best_q.found)
					cmd.op = OP_MATCH;
				else if (fire && !full)
					cmd.op = OP_NEW;
				else
					cmd.op = OP_NONE;
			end
			ST_MISS: cmd.op = OP_MISS;
			ST_PACK: cmd.op = OP_PACK;
			default: cmd.op = OP_NONE;
		endcase
	end

	assign spot_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cnt_q          <= '0;
			next_ident_q   <= 16'd1;
			alpha_start_q  <= 1'b0;
			result_valid_q <= 1'b0;
			best_q         <= '0;
			best_idx_q     <= '0;
		end else begin
			alpha_start_q  <= scan_end & cands[MAX_TRACKS].found;
			result_valid_q <= fire | (result_valid_q & ~result_ready);
			unique case (state_q)
				ST_IDLE: begin
					if (spot_valid) begin
						cnt_q <= '0;
						if (spot.kind)
							state_q <= ST_MISS;
						else
							state_q <= ST_SCAN;
					end
				end
				// distance pipes settle, then the candidate wave crosses the row
				ST_SCAN: begin
					if (scan_end) begin
						best_q     <= cands[MAX_TRACKS];
						best_idx_q <= cand_idxs[MAX_TRACKS];
						if (cands[MAX_TRACKS].found)
							state_q <= ST_ALPHA;
						else
							state_q <= ST_RESULT;
					end else
						cnt_q <= cnt_q + CW'(1);
				end
				ST_ALPHA: begin
					if (alpha_done) begin
						alpha_q <= alpha;
						state_q <= ST_BLEND;
					end
				end
				ST_BLEND: state_q <= ST_RESULT;
				ST_RESULT: begin
					if (fire) begin
						if (!best_q.found && !full)
							next_ident_q <= (next_ident_q == 16'hFFFF) ? 16'd1
								: next_ident_q + 16'd1;
						state_q <= ST_IDLE;
					end
				end
				ST_MISS: begin
					cnt_q   <= '0;
					state_q <= ST_PACK;
				end
				// each pass closes the lowest gap in the row
				ST_PACK: begin
					if (cnt_q == CW'(MAX_TRACKS - 1))
						state_q <= ST_IDLE;
					else
						cnt_q <= cnt_q + CW'(1);
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// spot payload and smoothing
	always_ff @(posedge clk) begin
		if (spot_valid && spot_ready) begin
			sx_q <= spot.spot_x;
			sy_q <= spot.spot_y;
			sr_q <= spot.has_radius ? spot.spot_radius : 16'd0;
		end
		if (state_q == ST_BLEND) begin
			bx_q <= blend_q8(best_q.smx, sx_q, alpha_q);
			by_q <= blend_q8(best_q.smy, sy_q, alpha_q);
			br_q <= blend_q8(best_q.smr, sr_q, RAD_ALPHA);
		end
	end

	// result register
	always_comb begin
		result_d = '0;
		if (best_q.found) begin
			result_d.track_number  = best_q.ident;
			result_d.track_age     = age_new;
			result_d.confirmed     = (age_new >= {9'd0, ck});
			result_d.smooth_x      = bx_q;
			result_d.smooth_y      = by_q;
			result_d.smooth_radius = br_q;
		end else if (full) begin
			result_d.table_full = 1'b1;
		end else begin
			result_d.track_number  = next_ident_q;
			result_d.track_age     = 17'd1;
			result_d.onset         = 1'b1;
			result_d.confirmed     = (ck == 8'd1);
			result_d.smooth_x      = sx_q;
			result_d.smooth_y      = sy_q;
			result_d.smooth_radius = sr_q;
		end
	end

	always_ff @(posedge clk) begin
		if (fire)
			result_q <= result_d;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// live tracks always sit at the bottom of the row between transactions
	a_compact: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> ((valid_vec & (valid_vec + 1'b1)) == '0))
		else $error("track row not compacted");

	a_claim_live: assert property (@(posedge clk) disable iff (!arst_n)
		(claimed_vec & ~valid_vec) == '0)
		else $error("claimed flag on a free slot");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q == ST_RESULT))
		else $error("result raised outside write-back");

	a_alpha_range: assert property (@(posedge clk) disable iff (!arst_n)
		alpha_done |-> (alpha >= 9'd72 && alpha <= 9'd218))
		else $error("position weight out of range");

endmodule

>>> verif/nearest_neighbour_spot_tracker_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nearest_neighbour_spot_tracker_test
// Self-checking bench for the spot tracker: directed and random spot frames
// run through several register settings and idling phases. Every verdict is
// predicted by a track-table model kept inside the bench and compared field by
// field in arrival order.
// ----------------------------------------------------------------------------
module nearest_neighbour_spot_tracker_test;
	import nnst_pkg::*;

	localparam int NTRK     = MAX_TRACKS_DEF;
	localparam int SETTLE   = 120;    // cycles to let an end of frame finish
	localparam int AGE_SAT  = 100000;

	logic      clk;
	logic      arst_n;
	logic      spot_valid;
	logic      spot_ready;
	in_item_t  spot;
	logic      result_valid;
	logic      result_ready;
	out_item_t result;
	logic      cfg_valid;
	logic      cfg_ready;
	logic [1:0] cfg_index;
	logic [9:0] cfg_data;

	nearest_neighbour_spot_tracker u_top (
		.clk(clk), .arst_n(arst_n),
		.spot_valid(spot_valid), .spot_ready(spot_ready), .spot(spot),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// stimulus waiting for the driver, verdicts waiting for the block
	in_item_t  spot_queue[$];
	out_item_t verdict_q[$];
	int        fail_count;
	int        send_gap_pct;
	int        recv_stall_pct;

	// ---------------- track table predictor ----------------
	int unsigned jump_px, confirm_n, drop_n;
	bit          trk_valid[NTRK];
	bit          trk_claimed[NTRK];
	bit [15:0]   trk_cx[NTRK], trk_cy[NTRK], trk_sx[NTRK], trk_sy[NTRK], trk_sr[NTRK];
	int unsigned trk_age[NTRK], trk_miss[NTRK];
	bit [15:0]   trk_id[NTRK];
	bit [15:0]   next_id;

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v -= root + bitv;
				root = (root >> 1) + bitv;
			end else
				root >>= 1;
			bitv >>= 2;
		end
		return root;
	endfunction

	function automatic bit [15:0] mix_q8(int unsigned s, int unsigned v, int unsigned a);
		int unsigned acc;
		acc = s * (256 - a) + v * a + 128;
		return acc[23:8];
	endfunction

	function automatic int live_tracks();
		int n;
		n = 0;
		while (n < NTRK && trk_valid[n]) n++;
		return n;
	endfunction

	// frame close: misses on unclaimed tracks, free the stale ones, compact
	function automatic void close_frame();
		int w, n;
		w = 0;
		n = live_tracks();
		for (int k = 0; k < n; k++) begin
			if (!trk_claimed[k]) begin
				if (trk_miss[k] + 1 > drop_n) continue;
				trk_miss[k]++;
				trk_age[k] = 0;
			end
			trk_cx[w] = trk_cx[k]; trk_cy[w] = trk_cy[k];
			trk_sx[w] = trk_sx[k]; trk_sy[w] = trk_sy[k]; trk_sr[w] = trk_sr[k];
			trk_age[w] = trk_age[k]; trk_miss[w] = trk_miss[k]; trk_id[w] = trk_id[k];
			w++;
		end
		for (int k = 0; k < NTRK; k++) begin
			trk_valid[k] = (k < w);
			trk_claimed[k] = 1'b0;
		end
	endfunction

	// work out the verdict of one accepted transaction and queue it
	function automatic void predict_verdict(in_item_t it);
		out_item_t       v;
		int              n, best;
		int unsigned     sr, ck, jq, dist_px, a;
		longint unsigned dx, dy, d2, best_d2, lim;
		if (it.kind) begin
			close_frame();
			return;
		end
		v = '0;
		sr = it.has_radius ? it.spot_radius : 0;
		ck = confirm_n ? confirm_n : 1;
		lim = longint'(jump_px * 16) * longint'(jump_px * 16);
		jq = (jump_px ? jump_px : 1) * 16;
		n = live_tracks();
		best = -1;
		best_d2 = 0;
		for (int k = 0; k < n; k++) begin
			if (trk_claimed[k]) continue;
			dx = trk_cx[k] >= it.spot_x ? trk_cx[k] - it.spot_x : it.spot_x - trk_cx[k];
			dy = trk_cy[k] >= it.spot_y ? trk_cy[k] - it.spot_y : it.spot_y - trk_cy[k];
			d2 = dx * dx + dy * dy;
			// later tracks win ties
			if (d2 <= lim && (best < 0 || d2 <= best_d2)) begin
				best = k;
				best_d2 = d2;
			end
		end
		if (best >= 0) begin
			dist_px = int_sqrt(best_d2);
			if (dist_px > jq) dist_px = jq;
			a = 72 + (146 * dist_px) / jq;
			trk_claimed[best] = 1'b1;
			trk_cx[best] = it.spot_x;
			trk_cy[best] = it.spot_y;
			trk_sx[best] = mix_q8(trk_sx[best], it.spot_x, a);
			trk_sy[best] = mix_q8(trk_sy[best], it.spot_y, a);
			trk_sr[best] = mix_q8(trk_sr[best], sr, 64);
			if (trk_age[best] < AGE_SAT) trk_age[best]++;
			trk_miss[best] = 0;
			v.track_number  = trk_id[best];
			v.track_age     = trk_age[best];
			v.confirmed     = trk_age[best] >= ck;
			v.smooth_x      = trk_sx[best];
			v.smooth_y      = trk_sy[best];
			v.smooth_radius = trk_sr[best];
		end else if (n >= NTRK) begin
			v.table_full = 1'b1;
		end else begin
			trk_valid[n] = 1'b1;
			trk_claimed[n] = 1'b1;
			trk_id[n] = next_id;
			next_id = next_id == 16'hFFFF ? 16'd1 : next_id + 16'd1;
			trk_cx[n] = it.spot_x; trk_cy[n] = it.spot_y;
			trk_sx[n] = it.spot_x; trk_sy[n] = it.spot_y; trk_sr[n] = sr;
			trk_age[n] = 1;
			trk_miss[n] = 0;
			v.track_number  = trk_id[n];
			v.track_age     = 1;
			v.onset         = 1'b1;
			v.confirmed     = ck <= 1;
			v.smooth_x      = it.spot_x;
			v.smooth_y      = it.spot_y;
			v.smooth_radius = sr;
		end
		verdict_q.insert(verdict_q.size(), v);
	endfunction

	// ---------------- clock, reset, limit ----------------
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("nearest_neighbour_spot_tracker regression: fail");
		$finish;
	end

	task automatic report(string what, longint unsigned got, longint unsigned want);
		$display("mismatch %s: got %0d, expected %0d (t=%0t)", what, got, want, $realtime);
		fail_count++;
	endtask

	// ---------------- driver ----------------
	// a new transaction is only put up once the previous one has gone
	always @(posedge clk) begin
		if (arst_n) begin
			if (!spot_valid || spot_ready) begin
				if (spot_valid)
					predict_verdict(spot);
				if (spot_queue.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
					spot <= spot_queue.pop_front();
					spot_valid <= 1'b1;
				end else begin
					spot_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------- monitor ----------------
	always @(posedge clk) begin
		out_item_t w;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (verdict_q.size() == 0) begin
					report("unexpected result transaction", 1, 0);
				end else begin
					w = verdict_q.pop_front();
					if (result.track_number !== w.track_number)
						report("track_number", result.track_number, w.track_number);
					if (result.track_age !== w.track_age)
						report("track_age", result.track_age, w.track_age);
					if (result.onset !== w.onset)
						report("onset", result.onset, w.onset);
					if (result.confirmed !== w.confirmed)
						report("confirmed", result.confirmed, w.confirmed);
					if (result.smooth_x !== w.smooth_x)
						report("smooth_x", result.smooth_x, w.smooth_x);
					if (result.smooth_y !== w.smooth_y)
						report("smooth_y", result.smooth_y, w.smooth_y);
					if (result.smooth_radius !== w.smooth_radius)
						report("smooth_radius", result.smooth_radius, w.smooth_radius);
					if (result.table_full !== w.table_full)
						report("table_full", result.table_full, w.table_full);
				end
			end
			result_ready <= $urandom_range(99) >= recv_stall_pct;
		end
	end

	// ---------------- stimulus helpers ----------------
	function automatic void add_spot(int x, int y, int r, bit has_r);
		in_item_t it;
		it.kind = 1'b0;
		it.spot_x = 16'(x);
		it.spot_y = 16'(y);
		it.spot_radius = 16'(r);
		it.has_radius = has_r;
		spot_queue.insert(spot_queue.size(), it);
	endfunction

	function automatic void add_frame_end();
		in_item_t it;
		it = '0;
		it.kind = 1'b1;
		// payload of a frame end is ignored; fill it anyway
		it.spot_x = 16'($urandom);
		it.spot_radius = 16'($urandom);
		spot_queue.insert(spot_queue.size(), it);
	endfunction

	function automatic int clamp16(int v);
		return v < 0 ? 0 : (v > 65535 ? 65535 : v);
	endfunction

	// only touched while the block is idle
	task automatic write_reg(logic [1:0] idx, int unsigned value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= 10'(value);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_MAX_JUMP: jump_px   = value & 10'h3FF;
			CFG_CONFIRM:  confirm_n = value & 8'hFF;
			CFG_DROP:     drop_n    = value & 8'hFF;
			default: ;
		endcase
	endtask

	// everything sent, every verdict in, frame-end work given time to finish
	task automatic drain();
		while (spot_queue.size() > 0 || spot_valid || verdict_q.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// a few moving objects seen with jitter, some clutter, now and then a crowd
	int obj_x[8], obj_y[8];

	task automatic random_frames(int n_items);
		int sent, nvis, o, jit, x, y;
		sent = 0;
		jit = jump_px * 12 + 1;
		while (sent < n_items) begin
			nvis = ($urandom_range(11) == 0) ? $urandom_range(17, 20) : $urandom_range(0, 6);
			for (int i = 0; i < nvis; i++) begin
				if (nvis > 8 || $urandom_range(7) == 0) begin
					x = $urandom_range(65535);
					y = $urandom_range(65535);
				end else begin
					o = $urandom_range(7);
					x = jump_px == 0 ? obj_x[o] : clamp16(obj_x[o] + $urandom_range(2 * jit) - jit);
					y = jump_px == 0 ? obj_y[o] : clamp16(obj_y[o] + $urandom_range(2 * jit) - jit);
				end
				add_spot(x, y, $urandom_range(1) ? $urandom_range(65535) : $urandom_range(400),
					$urandom_range(1));
			end
			add_frame_end();
			sent += nvis + 1;
			for (int k = 0; k < 8; k++) begin
				obj_x[k] = clamp16(obj_x[k] + $urandom_range(2 * jit) - jit);
				obj_y[k] = clamp16(obj_y[k] + $urandom_range(2 * jit) - jit);
			end
		end
	endtask

	// ---------------- main sequence ----------------
	initial begin
		int unsigned jumps[6]    = '{200, 64, 1, 1023, 0, 30};
		int unsigned confirms[6] = '{3, 3, 1, 255, 0, 2};
		int unsigned drops[6]    = '{5, 5, 0, 255, 1, 3};
		int          sgap[6]     = '{0, 45, 0, 37, 45, 0};
		int          rstall[6]   = '{0, 0, 45, 37, 45, 0};

		arst_n = 1'b0;
		spot_valid = 1'b0;
		spot = '0;
		result_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_MAX_JUMP;
		cfg_data = '0;
		fail_count = 0;
		send_gap_pct = 0;
		recv_stall_pct = 0;

		// predictor at its reset state
		jump_px = 64; confirm_n = 3; drop_n = 5;
		next_id = 16'd1;
		for (int k = 0; k < NTRK; k++) begin
			trk_valid[k] = 1'b0;
			trk_claimed[k] = 1'b0;
		end
		for (int k = 0; k < 8; k++) begin
			obj_x[k] = $urandom_range(65535);
			obj_y[k] = $urandom_range(65535);
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		for (int p = 0; p < 6; p++) begin
			drain();
			write_reg(CFG_MAX_JUMP, jumps[p]);
			write_reg(CFG_CONFIRM, confirms[p]);
			write_reg(CFG_DROP, drops[p]);
			send_gap_pct = sgap[p];
			recv_stall_pct = rstall[p];
			if (p == 0) begin
				// two tracks 200 px apart, then a spot halfway: the tie goes to the later one
				add_spot(100 * 16, 100 * 16, 50 * 16, 1'b1);
				add_spot(300 * 16, 100 * 16, 60 * 16, 1'b1);
				add_frame_end();
				add_spot(200 * 16, 100 * 16, 55 * 16, 1'b1);
				add_spot(200 * 16, 100 * 16, 0, 1'b0);
				add_frame_end();
				// field extremes
				add_spot(0, 0, 16'hFFFF, 1'b1);
				add_spot(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
				add_spot(16'hFFFF, 0, 0, 1'b1);
				add_frame_end();
				add_spot(0, 0, 16'hFFFF, 1'b1);
				add_frame_end();
			end else if (p == 2) begin
				// one-pixel jump radius, far-apart spots overflow the table
				for (int i = 0; i < NTRK + 2; i++)
					add_spot(i * 3000, 65535 - i * 3000, i * 100, i[0]);
				add_frame_end();
				add_frame_end();
			end else if (p == 4) begin
				// zero jump radius: only an identical centre is taken
				add_spot(5000, 6000, 800, 1'b1);
				add_frame_end();
				add_spot(5000, 6000, 900, 1'b1);
				add_spot(5001, 6000, 900, 1'b1);
				add_frame_end();
			end
			random_frames(135);
		end

		drain();
		if (fail_count == 0)
			$display("nearest_neighbour_spot_tracker regression: pass");
		else
			$display("nearest_neighbour_spot_tracker regression: fail");
		$finish;
	end

endmodule
